// ===== design/tiny_register_alu_executor_core_assert.svh =====
// Assertion macros for the tiny register ALU executor.
// Used by the top level only; expects signals clk and rst_n in scope.
`ifndef TINY_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH
`define TINY_REGISTER_ALU_EXECUTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TRAE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tiny_register_alu_executor_core: implication check failed");

// Next-cycle implication, checked outside reset.
`define TRAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tiny_register_alu_executor_core: next-cycle check failed");

`endif

// ===== design/trae_pkg.sv =====
// Shared types and constants for the tiny register ALU executor.
// No dependencies; used by every module of the block.
package trae_pkg;

  localparam int REG_W      = 4;   // register index / immediate width
  localparam int DATA_W     = 8;   // register width
  localparam int PC_W       = 16;  // instruction counter width
  localparam int QUEUE_DEPTH = 2;  // power of two

  localparam logic [7:0] OPC_ADD   = 8'h0C;
  localparam logic [7:0] OPC_SUB   = 8'h0D;
  localparam logic [7:0] OPC_MUL   = 8'h0E;
  localparam logic [7:0] OPC_DIV   = 8'h0F;
  localparam logic [7:0] OPC_COPY  = 8'h2C;
  localparam logic [7:0] OPC_LDI   = 8'h3C;
  localparam logic [7:0] OPC_CLEAR = 8'h4C;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_COPY  = 3'd4,
    OP_LDI   = 3'd5,
    OP_CLEAR = 3'd6,
    OP_BAD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADOP = 2'd1,
    ST_DIV0  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // decoded instruction word passed from front to back
  typedef struct packed {
    op_t               op;
    logic [REG_W-1:0]  reg_a;
    logic [REG_W-1:0]  field_b;
    logic              a_ok;
    logic              b_ok;
    logic [PC_W-1:0]   pc;
  } item_t;

  typedef struct packed {
    logic [PC_W-1:0]   pc_value;
    logic              write_enable;
    logic [REG_W-1:0]  write_index;
    logic [DATA_W-1:0] write_value;
    status_t           status;
  } res_t;

endpackage

// ===== design/trae_fifo.sv =====
// Small first-in first-out queue of trae_pkg::QUEUE_DEPTH words.
// Depends on trae_pkg for the depth.
module trae_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int DEPTH = trae_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== design/trae_front.sv =====
// Front end: decodes the opcode, checks register ranges and tags each word
// with the instruction counter. Depends on trae_pkg.
module trae_front #(
  parameter int NUM_REGS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   command,
  input  logic [trae_pkg::REG_W-1:0]   reg_a,
  input  logic [trae_pkg::REG_W-1:0]   field_b,
  output trae_pkg::item_t              item
);

  localparam int CMP_W = trae_pkg::REG_W + 1;

  logic [trae_pkg::PC_W-1:0] pc_r, pc_nxt;
  trae_pkg::op_t             op;

  always_comb begin
    case (command)
      trae_pkg::OPC_ADD:   op = trae_pkg::OP_ADD;
      trae_pkg::OPC_SUB:   op = trae_pkg::OP_SUB;
      trae_pkg::OPC_MUL:   op = trae_pkg::OP_MUL;
      trae_pkg::OPC_DIV:   op = trae_pkg::OP_DIV;
      trae_pkg::OPC_COPY:  op = trae_pkg::OP_COPY;
      trae_pkg::OPC_LDI:   op = trae_pkg::OP_LDI;
      trae_pkg::OPC_CLEAR: op = trae_pkg::OP_CLEAR;
      default:             op = trae_pkg::OP_BAD;
    endcase
  end

  always_comb begin
    item.op      = op;
    item.reg_a   = reg_a;
    item.field_b = field_b;
    item.a_ok    = ({1'b0, reg_a} < CMP_W'(NUM_REGS));
    item.b_ok    = ({1'b0, field_b} < CMP_W'(NUM_REGS));
    item.pc      = pc_r;
  end

  // counter advances on every accepted word, whatever its outcome
  assign pc_nxt = accept ? pc_r + trae_pkg::PC_W'(1) : pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/trae_div.sv =====
// Restoring 8-bit unsigned divider, one quotient bit per cycle.
// Depends on trae_pkg for the data width.
module trae_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [trae_pkg::DATA_W-1:0]   dividend,
  input  logic [trae_pkg::DATA_W-1:0]   divisor,
  output logic                          done,
  output logic [trae_pkg::DATA_W-1:0]   quotient
);

  localparam int DW    = trae_pkg::DATA_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      shifted;
  logic [DW+1:0]    diff;

  assign shifted  = {rem_r, quo_r[DW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the trial difference only when it did not go negative
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

endmodule

// ===== design/trae_back.sv =====
// Back end: register file, execution sequencer and write-back.
// Depends on trae_pkg and trae_div.
module trae_back #(
  parameter int NUM_REGS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  trae_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            res_full,
  output logic            res_push,
  output trae_pkg::res_t  res
);

  localparam int DW    = trae_pkg::DATA_W;
  localparam int IDX_W = $clog2(NUM_REGS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_WB   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  trae_pkg::item_t       item_r;
  logic [DW-1:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]   vld_r, vld_nxt;
  logic [DW-1:0]         rd_a_r, rd_b_r;
  logic                  a_ok_r, b_ok_r;
  logic [DW-1:0]         val_a, val_b;
  logic [DW-1:0]         value_r, value_nxt;
  logic                  want_r, want_nxt;
  trae_pkg::status_t     status_r, status_nxt;
  logic [2*DW-1:0]       product;
  logic                  div_start, div_done;
  logic [DW-1:0]         quotient;
  logic                  wrote;
  logic [IDX_W-1:0]      rd_idx_a, rd_idx_b, wr_idx;

  assign rd_idx_a = q_item.reg_a[IDX_W-1:0];
  assign rd_idx_b = q_item.field_b[IDX_W-1:0];
  assign wr_idx   = item_r.reg_a[IDX_W-1:0];

  // entries never written read as zero, as do indices past the file
  assign val_a   = a_ok_r ? rd_a_r : '0;
  assign val_b   = b_ok_r ? rd_b_r : '0;
  assign product = {{DW{1'b0}}, val_a} * {{DW{1'b0}}, val_b};

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = (state_r == S_EXEC) && (item_r.op == trae_pkg::OP_DIV)
                     && (val_b != '0);
  assign wrote     = want_r && item_r.a_ok;
  assign res_push  = (state_r == S_WB) && !res_full;

  always_comb begin
    res.pc_value     = item_r.pc;
    res.write_enable = wrote;
    res.write_index  = item_r.reg_a;
    res.write_value  = wrote ? value_r : '0;
    res.status       = status_r;
  end

  trae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_a),
    .divisor  (val_b),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt  = state_r;
    value_nxt  = value_r;
    want_nxt   = want_r;
    status_nxt = status_r;
    vld_nxt    = vld_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        want_nxt   = 1'b1;
        status_nxt = trae_pkg::ST_OK;
        state_nxt  = S_WB;
        case (item_r.op)
          trae_pkg::OP_ADD:   value_nxt = val_a + val_b;
          trae_pkg::OP_SUB:   value_nxt = val_a - val_b;
          trae_pkg::OP_MUL:   value_nxt = product[DW-1:0];
          trae_pkg::OP_DIV: begin
            value_nxt = '0;
            if (val_b == '0) begin
              want_nxt   = 1'b0;
              status_nxt = trae_pkg::ST_DIV0;
            end else begin
              state_nxt = S_DIV;
            end
          end
          trae_pkg::OP_COPY:  value_nxt = val_b;
          trae_pkg::OP_LDI:   value_nxt = DW'(item_r.field_b);
          trae_pkg::OP_CLEAR: value_nxt = '0;
          default: begin
            value_nxt  = '0;
            want_nxt   = 1'b0;
            status_nxt = trae_pkg::ST_BADOP;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          value_nxt = quotient;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (!res_full) begin
          if (wrote) begin
            vld_nxt[wr_idx] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    want_r   <= want_nxt;
    status_r <= status_nxt;
    if (q_pop) begin
      item_r <= q_item;
      rd_a_r <= rf_mem[rd_idx_a];
      rd_b_r <= rf_mem[rd_idx_b];
      a_ok_r <= q_item.a_ok && vld_r[rd_idx_a];
      b_ok_r <= q_item.b_ok && vld_r[rd_idx_b];
    end
    if (res_push && wrote) begin
      rf_mem[wr_idx] <= value_r;
    end
  end

endmodule

// ===== design/tiny_register_alu_executor_core.sv =====
// Tiny register ALU executor: runs one instruction word against a file of
// NUM_REGS 8-bit registers and reports one result word per instruction.
//
// Input channel: in_command, in_reg_a, in_field_b; a word is taken on a clock
// edge with in_push high and in_full low. Result channel: out_* fields are
// valid while out_empty is low and are taken on an edge with out_pop high.
// Each side has a two-word queue, so the source may keep pushing while a
// result waits to be popped and the sink may pop while work goes on.
// A word goes from the instruction queue through the execution sequencer
// (register read, execute, write-back) into the result queue; a divide also
// waits for the bit-serial divider, eight quotient bits at one per cycle.
// The sequencer takes a new word only after the last one is written back.
// Reset (rst_n low, synchronous) empties both queues, clears the instruction
// counter and marks every register as zero through its valid bit.
// When the sink stalls, the result queue fills, the sequencer holds in
// write-back, then the instruction queue fills and in_full rises.
// Depends on trae_pkg, trae_fifo, trae_front, trae_back, trae_div.
`include "tiny_register_alu_executor_core_assert.svh"

module tiny_register_alu_executor_core #(
  parameter int NUM_REGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_command,
  input  logic [3:0]  in_reg_a,
  input  logic [3:0]  in_field_b,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_pc_value,
  output logic        out_write_enable,
  output logic [3:0]  out_write_index,
  output logic [7:0]  out_write_value,
  output logic [1:0]  out_status
);

  localparam int ITEM_W = $bits(trae_pkg::item_t);
  localparam int RES_W  = $bits(trae_pkg::res_t);

  trae_pkg::item_t front_item, q_item;
  trae_pkg::res_t  back_res, out_res;
  logic            in_accept;
  logic            q_full, q_empty, q_pop;
  logic            res_full, res_push;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  trae_front #(.NUM_REGS(NUM_REGS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .command (in_command),
    .reg_a   (in_reg_a),
    .field_b (in_field_b),
    .item    (front_item)
  );

  trae_fifo #(.W(ITEM_W)) u_instr_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  trae_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  trae_fifo #(.W(RES_W)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_res),
    .empty (out_empty)
  );

  assign out_pc_value     = out_res.pc_value;
  assign out_write_enable = out_res.write_enable;
  assign out_write_index  = out_res.write_index;
  assign out_write_value  = out_res.write_value;
  assign out_status       = out_res.status;

  // a write only ever comes with a clean status
  `TRAE_ASSERT_IMPLY(a_write_ok, !out_empty && out_write_enable,
                     out_status == trae_pkg::ST_OK)
  // no value reported for a word that wrote nothing
  `TRAE_ASSERT_IMPLY(a_nowrite_zero, !out_empty && !out_write_enable,
                     out_write_value == 8'd0)
  // an accepted word is queued for the back end on the next cycle
  `TRAE_ASSERT_NEXT(a_accept_queued, in_accept, !q_empty)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tiny_register_alu_executor_core: drives instruction words,
// predicts every result word from a shadow register file and compares them in order.
// Depends on trae_pkg and the design sources only.

module testbench;
  import trae_pkg::*;

  localparam int NUM_REGS       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  // opcodes the block does not know
  localparam logic [7:0] OPC_UNUSED_LO   = 8'h00;
  localparam logic [7:0] OPC_UNUSED_HI   = 8'hFF;
  localparam logic [7:0] OPC_NEAR_ADD    = 8'h0B;
  localparam logic [7:0] OPC_NEAR_CLEAR  = 8'h4D;
  localparam logic [7:0] OPC_WRONG_GROUP = 8'h1C;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              in_push          = 1'b0;
  logic              in_full;
  logic [7:0]        in_command       = '0;
  logic [REG_W-1:0]  in_reg_a         = '0;
  logic [REG_W-1:0]  in_field_b       = '0;
  logic              out_empty;
  logic              out_pop          = 1'b0;
  logic [PC_W-1:0]   out_pc_value;
  logic              out_write_enable;
  logic [REG_W-1:0]  out_write_index;
  logic [DATA_W-1:0] out_write_value;
  logic [1:0]        out_status;

  logic [DATA_W-1:0] reg_shadow [NUM_REGS];
  logic [PC_W-1:0]   pc_shadow;
  res_t              pending_results [$];
  int                fail_count = 0;
  int                stall_left = 0;
  bit                idling_on  = 1'b0;

  tiny_register_alu_executor_core #(
    .NUM_REGS(NUM_REGS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_reg_a        (in_reg_a),
    .in_field_b      (in_field_b),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pc_value    (out_pc_value),
    .out_write_enable(out_write_enable),
    .out_write_index (out_write_index),
    .out_write_value (out_write_value),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Execute one instruction on the shadow state and return the result word it yields.
  function automatic res_t execute_instr(input logic [7:0] cmd, input logic [REG_W-1:0] ra,
                                         input logic [REG_W-1:0] fb);
    res_t              res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] value;
    logic              wr;
    status_t           st;
    a     = (ra < NUM_REGS) ? reg_shadow[ra] : '0;
    b     = (fb < NUM_REGS) ? reg_shadow[fb] : '0;
    value = '0;
    st    = ST_OK;
    wr    = 1'b1;
    case (cmd)
      OPC_ADD:   value = a + b;
      OPC_SUB:   value = a - b;
      OPC_MUL:   value = a * b;
      OPC_DIV: begin
        if (b == '0) begin
          st = ST_DIV0;
          wr = 1'b0;
        end else begin
          value = a / b;
        end
      end
      OPC_COPY:  value = b;
      OPC_LDI:   value = {{(DATA_W-REG_W){1'b0}}, fb};
      OPC_CLEAR: value = '0;
      default: begin
        st = ST_BADOP;
        wr = 1'b0;
      end
    endcase
    if (wr && ra < NUM_REGS) begin
      reg_shadow[ra] = value;
    end else begin
      wr    = 1'b0;
      value = '0;
    end
    res.pc_value     = pc_shadow;
    res.write_enable = wr;
    res.write_index  = ra;
    res.write_value  = value;
    res.status       = st;
    pc_shadow        = pc_shadow + 1'b1;
    return res;
  endfunction

  function automatic logic [7:0] pick_command();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 14) return OPC_ADD;
    if (roll < 28) return OPC_SUB;
    if (roll < 40) return OPC_MUL;
    if (roll < 50) return OPC_DIV;
    if (roll < 62) return OPC_COPY;
    if (roll < 80) return OPC_LDI;
    if (roll < 88) return OPC_CLEAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Hold the word on the ports until it is taken, then log its expected result.
  task automatic send_instr(input logic [7:0] cmd, input logic [REG_W-1:0] ra,
                            input logic [REG_W-1:0] fb);
    in_push    <= 1'b1;
    in_command <= cmd;
    in_reg_a   <= ra;
    in_field_b <= fb;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_results.push_back(execute_instr(cmd, ra, fb));
  endtask

  task automatic pause_input(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_items(input int count);
    repeat (count) begin
      if (idling_on && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 6));
      send_instr(pick_command(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_directed_ops();
    send_instr(OPC_LDI,   4'd0,  4'd15);
    send_instr(OPC_LDI,   4'd15, 4'd1);
    send_instr(OPC_CLEAR, 4'd1,  4'd0);
    send_instr(OPC_SUB,   4'd1,  4'd15);  // 0 - 1 wraps to 255
    send_instr(OPC_COPY,  4'd2,  4'd1);
    send_instr(OPC_ADD,   4'd2,  4'd1);   // carry out dropped
    send_instr(OPC_MUL,   4'd1,  4'd1);   // keep low byte of 255 * 255
    send_instr(OPC_COPY,  4'd3,  4'd2);
    send_instr(OPC_DIV,   4'd3,  4'd0);
    send_instr(OPC_DIV,   4'd2,  4'd15);
    send_instr(OPC_DIV,   4'd0,  4'd14);  // divisor register still zero
    send_instr(OPC_DIV,   4'd14, 4'd14);
    send_instr(OPC_MUL,   4'd15, 4'd0);
    send_instr(OPC_LDI,   4'd7,  4'd0);
    send_instr(OPC_COPY,  4'd15, 4'd15);
    send_instr(OPC_CLEAR, 4'd15, 4'd15);
    send_instr(OPC_UNUSED_LO,   4'd0,  4'd0);
    send_instr(OPC_UNUSED_HI,   4'd15, 4'd15);
    send_instr(OPC_NEAR_ADD,    4'd1,  4'd2);
    send_instr(OPC_NEAR_CLEAR,  4'd3,  4'd0);
    send_instr(OPC_WRONG_GROUP, 4'd2,  4'd7);
    send_instr(OPC_ADD,   4'd14, 4'd14);
  endtask

  task automatic test_random_program();
    idling_on = 1'b1;
    run_random_items(900);
  endtask

  task automatic test_drain_pause();
    run_random_items(60);
    wait_for_drain();
    run_random_items(60);
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    run_random_items(200);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Take result words, compare with the oldest expectation, and, while idling is on, stall the pop at random.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected, got pc %0h", $time, out_pc_value);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("pc_value", want.pc_value, out_pc_value);
          compare_field("write_enable", want.write_enable, out_write_enable);
          compare_field("write_index", want.write_index, out_write_index);
          compare_field("write_value", want.write_value, out_write_value);
          compare_field("status", want.status, out_status);
        end
      end
      if (idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left != 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    foreach (reg_shadow[i]) reg_shadow[i] = '0;
    pc_shadow = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_program();
    test_drain_pause();
    test_steady_stream();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== tiny_register_alu_executor_core.f =====
+incdir+design
design/trae_pkg.sv
design/trae_fifo.sv
design/trae_front.sv
design/trae_div.sv
design/trae_back.sv
design/tiny_register_alu_executor_core.sv
dv/testbench.sv
